// ----- src/fsb_pkg.sv -----
// ----------------------------------------------------------------------------
// fsb_pkg: shared types and constants of the framebuffer sprite blitter
// Command codes, register indexes, sequencer states and the config struct.
// ----------------------------------------------------------------------------
package fsb_pkg;

  localparam int FSB_MAX_FB_WIDTH   = 256;
  localparam int FSB_MAX_FB_HEIGHT  = 256;
  localparam int FSB_MAX_SPRITE_DIM = 16;

  // mask rows are 16 bits wide, so no sprite is wider than this
  localparam int FSB_MASK_W = 16;

  localparam int FSB_CFG_ADDR_W = 3;

  localparam logic [8:0] FSB_WIDTH_RST  = 9'd224;
  localparam logic [8:0] FSB_HEIGHT_RST = 9'd256;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2,
    CMD_READ  = 2'd3
  } fsb_cmd_t;

  typedef enum logic {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } fsb_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR_MUL,
    S_CLR_RUN,
    S_DRW_ROW,
    S_DRW_PIX,
    S_RD_MUL,
    S_RD_MEM,
    S_RD_DATA
  } fsb_state_t;

  typedef struct packed {
    logic [8:0] active_width;
    logic [8:0] active_height;
  } fsb_cfg_t;

endpackage

// ----- src/fsb_ram.sv -----
// ----------------------------------------------------------------------------
// fsb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module fsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fsb_cfg.sv -----
// ----------------------------------------------------------------------------
// fsb_cfg: configuration register file
// APB-style slave holding the active framebuffer width and height.
// ----------------------------------------------------------------------------
module fsb_cfg
  import fsb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [FSB_CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output fsb_cfg_t                  cfg
);

  logic [8:0] width_r;
  logic [8:0] height_r;
  logic       wr_en;
  fsb_reg_t   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = fsb_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FSB_WIDTH_RST;
      height_r <= FSB_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ACTIVE_WIDTH:  width_r  <= pwdata[8:0];
        REG_ACTIVE_HEIGHT: height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACTIVE_WIDTH:  prdata = {23'd0, width_r};
      REG_ACTIVE_HEIGHT: prdata = {23'd0, height_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg.active_width  = width_r;
  assign cfg.active_height = height_r;

endmodule

// ----- src/framebuffer_sprite_blitter_core.sv -----
// ----------------------------------------------------------------------------
// framebuffer_sprite_blitter_core: 32-bit framebuffer with 1bpp sprite draw
// Clear: S_CLR_MUL, then S_CLR_RUN sweeps the area; draw: S_DRW_ROW per row, S_DRW_PIX per pixel.
// Read: S_RD_MUL, S_RD_MEM, S_RD_DATA. Load and a zero-size draw answer from idle.
// At most one frame RAM word is written per cycle; draw writes only set mask bits in the area.
// One command at a time: busy stays high until its result shows; load and a zero-size
// draw never raise it. The result strobe lasts one cycle and cannot be stalled.
// Reset clears the sequencer and loads the config defaults (224 by 256); RAMs keep garbage.
// ----------------------------------------------------------------------------
module framebuffer_sprite_blitter_core
  import fsb_pkg::*;
#(
  parameter int MAX_FB_WIDTH   = FSB_MAX_FB_WIDTH,
  parameter int MAX_FB_HEIGHT  = FSB_MAX_FB_HEIGHT,
  parameter int MAX_SPRITE_DIM = FSB_MAX_SPRITE_DIM
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic signed [8:0]         in_x_pos,
  input  logic signed [8:0]         in_y_pos,
  input  logic [31:0]               in_pixel_color,
  input  logic [4:0]                in_sprite_cols,
  input  logic [4:0]                in_sprite_rows_used,
  input  logic [3:0]                in_row_index,
  input  logic [15:0]               in_row_mask,
  output logic                      out_valid,
  output logic [31:0]               out_read_color,
  output logic [16:0]               out_pixels_written,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [FSB_CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int FB_DEPTH = MAX_FB_WIDTH * MAX_FB_HEIGHT;
  localparam int FAW      = $clog2(FB_DEPTH);
  localparam int NW       = $clog2(FB_DEPTH + 1);
  localparam int WA       = $clog2(MAX_FB_WIDTH);
  localparam int WW       = $clog2(MAX_FB_WIDTH + 1);
  localparam int HA       = $clog2(MAX_FB_HEIGHT);
  localparam int HW       = $clog2(MAX_FB_HEIGHT + 1);
  localparam int CLIM     = (MAX_SPRITE_DIM < FSB_MASK_W) ? MAX_SPRITE_DIM : FSB_MASK_W;
  localparam int SDW      = $clog2(MAX_SPRITE_DIM + 1);
  localparam int XW       = $clog2(CLIM);
  localparam int YW       = $clog2(MAX_SPRITE_DIM);
  localparam int PW       = 11 + SDW;

  fsb_cfg_t cfg;

  fsb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamp the active area to the physical frame
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  assign eff_w = (32'(cfg.active_width) > MAX_FB_WIDTH) ? WW'(MAX_FB_WIDTH)
               : WW'(cfg.active_width);
  assign eff_h = (32'(cfg.active_height) > MAX_FB_HEIGHT) ? HW'(MAX_FB_HEIGHT)
               : HW'(cfg.active_height);

  logic [SDW-1:0] cols_in;
  logic [SDW-1:0] rows_in;

  assign cols_in = (32'(in_sprite_cols) > CLIM) ? SDW'(CLIM) : SDW'(in_sprite_cols);
  assign rows_in = (32'(in_sprite_rows_used) > MAX_SPRITE_DIM) ? SDW'(MAX_SPRITE_DIM)
                 : SDW'(in_sprite_rows_used);

  // sequencer and datapath registers
  fsb_state_t           state_r, state_nxt;
  logic signed [8:0]    xp_r, xp_nxt;
  logic signed [8:0]    yp_r, yp_nxt;
  logic [31:0]          color_r, color_nxt;
  logic [SDW-1:0]       cols_r, cols_nxt;
  logic [SDW-1:0]       rows_r, rows_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [YW-1:0]        y_r, y_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        prod_r, prod_nxt;
  logic                 area_ok_r, area_ok_nxt;
  logic [FSB_MASK_W-1:0] mask_r, mask_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_color_r, out_color_nxt;
  logic [16:0]          out_count_r, out_count_nxt;

  // RAM ports
  logic                  fb_we;
  logic [FAW-1:0]        fb_waddr;
  logic                  fb_re;
  logic [FAW-1:0]        fb_raddr;
  logic [31:0]           fb_rdata;
  logic                  spr_we;
  logic                  spr_re;
  logic [FSB_MASK_W-1:0] spr_rdata;
  logic [YW-1:0]         spr_waddr;

  fsb_ram #(.WIDTH(32), .DEPTH(FB_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (color_r),
    .re    (fb_re),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  fsb_ram #(.WIDTH(FSB_MASK_W), .DEPTH(MAX_SPRITE_DIM)) u_mask_ram (
    .clk   (clk),
    .we    (spr_we),
    .waddr (spr_waddr),
    .wdata (in_row_mask),
    .re    (spr_re),
    .raddr (y_r),
    .rdata (spr_rdata)
  );

  assign spr_waddr = YW'(in_row_index);

  // coordinates of the current pixel
  logic signed [PW-1:0] col_s;
  logic signed [PW-1:0] row_s;
  logic signed [PW-1:0] ry_s;
  logic                 col_ok;
  logic                 rowd_ok;
  logic                 rowr_ok;
  logic [HW-1:0]        mul_a;
  logic [HW+WW-1:0]     mul_p;
  logic [FSB_MASK_W-1:0] mask_cur;
  logic                 last_x;
  logic                 last_y;
  logic                 ld_ok;

  assign col_s = PW'(xp_r) + PW'(x_r);
  assign row_s = PW'(yp_r) + PW'(rows_r) - PW'(y_r) - PW'(1);
  assign ry_s  = PW'(yp_r);

  assign col_ok  = !col_s[PW-1] && ($unsigned(col_s) < PW'(eff_w));
  assign rowd_ok = !row_s[PW-1] && ($unsigned(row_s) < PW'(eff_h));
  assign rowr_ok = !ry_s[PW-1]  && ($unsigned(ry_s)  < PW'(eff_h));

  assign mul_p = mul_a * eff_w;

  assign mask_cur = (x_r == '0) ? spr_rdata : mask_r;
  assign last_x   = (SDW'(x_r) == cols_r - SDW'(1));
  assign last_y   = (SDW'(y_r) == rows_r - SDW'(1));
  assign ld_ok    = 32'(in_row_index) < MAX_SPRITE_DIM;

  assign fb_raddr = prod_r[FAW-1:0] + FAW'(col_s[WA-1:0]);

  always_comb begin
    state_nxt     = state_r;
    xp_nxt        = xp_r;
    yp_nxt        = yp_r;
    color_nxt     = color_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    area_ok_nxt   = area_ok_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_color_nxt = out_color_r;
    out_count_nxt = out_count_r;
    fb_we         = 1'b0;
    fb_waddr      = cnt_r[FAW-1:0];
    fb_re         = 1'b0;
    spr_we        = 1'b0;
    spr_re        = 1'b0;
    mul_a         = HW'(ry_s[HA-1:0]);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          xp_nxt    = in_x_pos;
          yp_nxt    = in_y_pos;
          color_nxt = in_pixel_color;
          cols_nxt  = cols_in;
          rows_nxt  = rows_in;
          x_nxt     = '0;
          y_nxt     = '0;
          cnt_nxt   = '0;
          case (fsb_cmd_t'(in_command))
            CMD_CLEAR: state_nxt = S_CLR_MUL;
            CMD_LOAD: begin
              spr_we        = ld_ok;
              out_valid_nxt = 1'b1;
              out_color_nxt = '0;
              out_count_nxt = '0;
            end
            CMD_DRAW: begin
              if (cols_in == '0 || rows_in == '0) begin
                out_valid_nxt = 1'b1;
                out_color_nxt = '0;
                out_count_nxt = '0;
              end else begin
                state_nxt = S_DRW_ROW;
              end
            end
            CMD_READ: state_nxt = S_RD_MUL;
            default: ;
          endcase
        end
      end

      S_CLR_MUL: begin
        mul_a     = eff_h;
        prod_nxt  = NW'(mul_p);
        state_nxt = S_CLR_RUN;
      end

      // sweep every word of the active area, one a cycle
      S_CLR_RUN: begin
        if (cnt_r == prod_r) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = '0;
          out_count_nxt = 17'(cnt_r);
          state_nxt     = S_IDLE;
        end else begin
          fb_we   = 1'b1;
          cnt_nxt = cnt_r + NW'(1);
        end
      end

      // fetch the mask row and form the frame row base address
      S_DRW_ROW: begin
        spr_re      = 1'b1;
        mul_a       = HW'(row_s[HA-1:0]);
        prod_nxt    = NW'(mul_p);
        area_ok_nxt = rowd_ok;
        x_nxt       = '0;
        state_nxt   = S_DRW_PIX;
      end

      S_DRW_PIX: begin
        fb_waddr = prod_r[FAW-1:0] + FAW'(col_s[WA-1:0]);
        fb_we    = mask_cur[0] && area_ok_r && col_ok;
        mask_nxt = mask_cur >> 1;
        cnt_nxt  = fb_we ? cnt_r + NW'(1) : cnt_r;
        if (last_x) begin
          if (last_y) begin
            out_valid_nxt = 1'b1;
            out_color_nxt = '0;
            out_count_nxt = 17'(cnt_nxt);
            state_nxt     = S_IDLE;
          end else begin
            y_nxt     = y_r + YW'(1);
            state_nxt = S_DRW_ROW;
          end
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end

      S_RD_MUL: begin
        prod_nxt    = NW'(mul_p);
        area_ok_nxt = col_ok && rowr_ok;
        state_nxt   = S_RD_MEM;
      end

      S_RD_MEM: begin
        fb_re     = area_ok_r;
        state_nxt = S_RD_DATA;
      end

      S_RD_DATA: begin
        out_valid_nxt = 1'b1;
        out_color_nxt = area_ok_r ? fb_rdata : '0;
        out_count_nxt = '0;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xp_r        <= xp_nxt;
    yp_r        <= yp_nxt;
    color_r     <= color_nxt;
    cols_r      <= cols_nxt;
    rows_r      <= rows_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    area_ok_r   <= area_ok_nxt;
    mask_r      <= mask_nxt;
    out_color_r <= out_color_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_read_color     = out_color_r;
  assign out_pixels_written = out_count_r;

  // frame writes come only from the clear sweep or the draw walk
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    fb_we |-> (state_r == S_CLR_RUN || state_r == S_DRW_PIX))
    else $error("frame write outside clear or draw");

  a_clr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR_RUN && fb_we) |-> (cnt_r < prod_r))
    else $error("clear sweep past the active area");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted command neither answered nor in progress");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a command is still running");

endmodule
